// ===== src/slmli_pkg.sv =====
// Types and constants shared by the response table interpolator modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package slmli_pkg;

  localparam int MODE_W = 2;
  localparam int CS_W   = 4;
  localparam int PS_W   = 6;
  localparam int PT_W   = 7;
  localparam int WL_W   = 24;
  localparam int CMD_W  = 17;
  localparam int AMP_W  = 17;
  localparam int PH_W   = 24;
  localparam int CFG_W  = 5;
  // internal signed width for amplitude and phase arithmetic
  localparam int VAL_W  = 26;
  // operand width of the fraction divider
  localparam int DIV_W  = 24;

  localparam logic [CMD_W-1:0] CMD_ONE = 17'h10000;

  typedef enum logic [MODE_W-1:0] {
    MODE_HEADER = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                   mode;
    logic [CS_W-1:0]         curve_slot;
    logic [PS_W-1:0]         point_slot;
    logic [PT_W-1:0]         point_total;
    logic [WL_W-1:0]         wavelength;
    logic [CMD_W-1:0]        command;
    logic [AMP_W-1:0]        amplitude;
    logic signed [PH_W-1:0]  phase;
  } slm_in_t;

  typedef struct packed {
    logic [AMP_W-1:0]        transmission;
    logic signed [PH_W-1:0]  phase_delay;
    logic                    status;
  } slm_out_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [AMP_W-1:0]        amp;
    logic signed [PH_W-1:0]  ph;
  } pt_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_WL_LAST,
    OP_WL_START,
    OP_WL_STEP,
    OP_CNT_LO,
    OP_CNT_UP,
    OP_PT_START,
    OP_PT_STEP,
    OP_TAKE_PT,
    OP_DIV_CMD,
    OP_DIV_WL,
    OP_DIV_STEP,
    OP_MUL_AMP_C,
    OP_MUL_PH_C,
    OP_MUL_AMP_W,
    OP_MUL_PH_W,
    OP_ADD_AMP,
    OP_ADD_PH,
    OP_SAVE_LO,
    OP_EMIT_OK,
    OP_EMIT_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic query_start;
    logic wl_ge;
    logic wl_exact;
    logic wl_first;
    logic wl_oob;
    logic pt_ge;
    logic pt_exact;
    logic pt_first;
    logic pt_last;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/slmli_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module slmli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/slmli_dp.sv =====
// Datapath: table memories, search registers, fraction divider and shared
// multiplier. Depends on slmli_pkg and slmli_ram.
`timescale 1ns / 1ps
`default_nettype none

module slmli_dp import slmli_pkg::*; #(
  parameter int MAX_CURVES = 16,
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  slm_in_t          in_data,
  input  logic             in_accept,
  input  logic             cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             out_stall,
  output logic             out_valid,
  output slm_out_t         out_data
);

  localparam int CAW = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;
  localparam int CNW = $clog2(MAX_CURVES + 1);
  localparam int PIW = $clog2(MAX_POINTS);
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int PDEPTH = MAX_CURVES * MAX_POINTS;
  localparam int PAW = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int CTW = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
  localparam int PW  = $bits(pt_t);
  localparam int PRW = VAL_W + FRAC_BITS;

  logic [CFG_W-1:0]        curves_cfg;
  logic [CNW-1:0]          ncur;
  logic [WL_W-1:0]         q_wl;
  logic [CMD_W-1:0]        q_cmd;
  logic [CAW-1:0]          cidx;
  logic [CAW-1:0]          up_curve;
  logic [CAW-1:0]          cur_curve;
  logic [WL_W-1:0]         last_wl;
  logic [WL_W-1:0]         prev_wl;
  logic [WL_W-1:0]         hi_wl;
  logic [PCW-1:0]          npts;
  logic [PIW-1:0]          pidx;
  pt_t                     prev_pt;
  pt_t                     cur_pt;
  logic [DIV_W-1:0]        rem;
  logic [DIV_W-1:0]        den;
  logic [FRAC_BITS-1:0]    frac;
  logic [CTW-1:0]          dcnt;
  logic [PRW-1:0]          prod;
  logic                    prod_neg;
  logic signed [VAL_W-1:0] a_hold;
  logic signed [VAL_W-1:0] amp_res;
  logic signed [VAL_W-1:0] ph_res;
  logic signed [VAL_W-1:0] lo_amp;
  logic signed [VAL_W-1:0] lo_ph;

  // load decoding
  logic           hdr_we;
  logic           pt_we;
  logic [PCW-1:0] hdr_cnt;
  logic [CAW-1:0] slot_addr;
  logic [PAW-1:0] pt_waddr;
  pt_t            pt_wdata;

  assign hdr_we    = in_accept && (in_data.mode == MODE_HEADER)
                     && (int'(in_data.curve_slot) < MAX_CURVES);
  assign pt_we     = in_accept && (in_data.mode == MODE_POINT)
                     && (int'(in_data.curve_slot) < MAX_CURVES)
                     && (int'(in_data.point_slot) < MAX_POINTS);
  assign slot_addr = CAW'(in_data.curve_slot);
  assign pt_waddr  = PAW'(int'(in_data.curve_slot) * MAX_POINTS + int'(in_data.point_slot));
  assign pt_wdata  = '{cmd: in_data.command, amp: in_data.amplitude, ph: in_data.phase};

  always_comb begin
    if (in_data.point_total == '0) begin
      hdr_cnt = PCW'(1);
    end else if (int'(in_data.point_total) > MAX_POINTS) begin
      hdr_cnt = PCW'(MAX_POINTS);
    end else begin
      hdr_cnt = PCW'(in_data.point_total);
    end
  end

  // read addresses
  logic [CAW-1:0]  wl_raddr;
  logic [CAW-1:0]  cnt_raddr;
  logic [PAW-1:0]  pbase;
  logic [PAW-1:0]  pt_raddr;
  logic [WL_W-1:0] wl_rd;
  logic [PCW-1:0]  cnt_rd;
  logic [PW-1:0]   pt_rword;
  pt_t             pt_rd;

  always_comb begin
    unique case (cmd.op)
      OP_WL_LAST:  wl_raddr = CAW'(ncur - CNW'(1));
      OP_WL_START: wl_raddr = '0;
      default:     wl_raddr = CAW'(cidx + CAW'(1));
    endcase
  end

  assign cnt_raddr = (cmd.op == OP_CNT_LO) ? CAW'(up_curve - CAW'(1)) : up_curve;
  assign pbase     = PAW'(int'(cur_curve) * MAX_POINTS);
  assign pt_raddr  = (cmd.op == OP_PT_START) ? pbase : PAW'(pbase + PAW'(pidx) + PAW'(1));
  assign pt_rd     = pt_t'(pt_rword);

  slmli_ram #(.WIDTH(WL_W), .DEPTH(MAX_CURVES)) u_wl_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (slot_addr),
    .wdata (in_data.wavelength),
    .raddr (wl_raddr),
    .rdata (wl_rd)
  );

  slmli_ram #(.WIDTH(PCW), .DEPTH(MAX_CURVES)) u_cnt_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (slot_addr),
    .wdata (hdr_cnt),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  slmli_ram #(.WIDTH(PW), .DEPTH(PDEPTH)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rword)
  );

  // status
  assign stat.query_start = in_accept && (in_data.mode == MODE_QUERY);
  assign stat.wl_ge       = wl_rd >= q_wl;
  assign stat.wl_exact    = wl_rd == q_wl;
  assign stat.wl_first    = cidx == '0;
  assign stat.wl_oob      = (q_wl < wl_rd) || (q_wl > last_wl);
  assign stat.pt_ge       = pt_rd.cmd >= q_cmd;
  assign stat.pt_exact    = pt_rd.cmd == q_cmd;
  assign stat.pt_first    = pidx == '0;
  assign stat.pt_last     = PCW'(pidx) == (npts - PCW'(1));
  assign stat.div_last    = dcnt == CTW'(FRAC_BITS - 1);
  assign stat.out_free    = !out_valid || !out_stall;

  // divider operands and step
  logic [DIV_W-1:0] dx;
  logic [DIV_W-1:0] dlo;
  logic [DIV_W-1:0] dhi;
  logic [DIV_W:0]   r2;
  logic [DIV_W:0]   rdiff;
  logic             rge;

  always_comb begin
    if (cmd.op == OP_DIV_WL) begin
      dx  = DIV_W'(q_wl);
      dlo = DIV_W'(prev_wl);
      dhi = DIV_W'(hi_wl);
    end else begin
      dx  = DIV_W'(q_cmd);
      dlo = DIV_W'(prev_pt.cmd);
      dhi = DIV_W'(cur_pt.cmd);
    end
  end

  assign r2    = {rem, 1'b0};
  assign rdiff = r2 - {1'b0, den};
  assign rge   = r2 >= {1'b0, den};

  // multiplier operands
  logic signed [VAL_W-1:0] ma;
  logic signed [VAL_W-1:0] mb;
  logic signed [VAL_W-1:0] mdiff;
  logic [VAL_W-1:0]        mmag;
  logic [VAL_W-1:0]        mq;
  logic signed [VAL_W-1:0] addv;

  always_comb begin
    unique case (cmd.op)
      OP_MUL_AMP_C: begin
        ma = $signed(VAL_W'(prev_pt.amp));
        mb = $signed(VAL_W'(cur_pt.amp));
      end
      OP_MUL_AMP_W: begin
        ma = lo_amp;
        mb = amp_res;
      end
      OP_MUL_PH_W: begin
        ma = lo_ph;
        mb = ph_res;
      end
      default: begin
        ma = VAL_W'(prev_pt.ph);
        mb = VAL_W'(cur_pt.ph);
      end
    endcase
  end

  assign mdiff = mb - ma;
  assign mmag  = mdiff[VAL_W-1] ? VAL_W'(-mdiff) : VAL_W'(mdiff);
  assign mq    = prod[PRW-1:FRAC_BITS];
  assign addv  = prod_neg ? (a_hold - $signed(mq)) : (a_hold + $signed(mq));

  // configuration and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      curves_cfg <= CFG_W'(1);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        curves_cfg <= cfg_wdata;
      end
      if (cmd.op == OP_EMIT_OK || cmd.op == OP_EMIT_ERR) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.query_start) begin
      q_wl <= in_data.wavelength;
      q_cmd <= (in_data.command > CMD_ONE) ? CMD_ONE : in_data.command;
      if (curves_cfg == '0) begin
        ncur <= CNW'(1);
      end else if (int'(curves_cfg) > MAX_CURVES) begin
        ncur <= CNW'(MAX_CURVES);
      end else begin
        ncur <= CNW'(curves_cfg);
      end
    end

    unique case (cmd.op)
      OP_WL_START: begin
        last_wl <= wl_rd;
        cidx    <= '0;
      end
      OP_WL_STEP: begin
        if (stat.wl_ge) begin
          hi_wl    <= wl_rd;
          up_curve <= cidx;
        end else begin
          prev_wl <= wl_rd;
          cidx    <= CAW'(cidx + CAW'(1));
        end
      end
      OP_CNT_LO, OP_CNT_UP: begin
        cur_curve <= cnt_raddr;
      end
      OP_PT_START: begin
        npts <= cnt_rd;
        pidx <= '0;
      end
      OP_PT_STEP: begin
        cur_pt <= pt_rd;
        if (!stat.pt_ge && !stat.pt_last) begin
          prev_pt <= pt_rd;
          pidx    <= PIW'(pidx + PIW'(1));
        end
      end
      OP_TAKE_PT: begin
        amp_res <= $signed(VAL_W'(cur_pt.amp));
        ph_res  <= VAL_W'(cur_pt.ph);
      end
      OP_DIV_CMD, OP_DIV_WL: begin
        rem  <= dx - dlo;
        den  <= dhi - dlo;
        frac <= '0;
        dcnt <= '0;
      end
      OP_DIV_STEP: begin
        rem  <= rge ? rdiff[DIV_W-1:0] : r2[DIV_W-1:0];
        frac <= {frac[FRAC_BITS-2:0], rge};
        dcnt <= CTW'(dcnt + CTW'(1));
      end
      OP_MUL_AMP_C, OP_MUL_PH_C, OP_MUL_AMP_W, OP_MUL_PH_W: begin
        prod     <= PRW'(mmag) * PRW'(frac);
        prod_neg <= mdiff[VAL_W-1];
        a_hold   <= ma;
      end
      OP_ADD_AMP: begin
        amp_res <= addv;
      end
      OP_ADD_PH: begin
        ph_res <= addv;
      end
      OP_SAVE_LO: begin
        lo_amp <= amp_res;
        lo_ph  <= ph_res;
      end
      OP_EMIT_OK: begin
        out_data.transmission <= amp_res[AMP_W-1:0];
        out_data.phase_delay  <= ph_res[PH_W-1:0];
        out_data.status       <= 1'b0;
      end
      OP_EMIT_ERR: begin
        out_data.transmission <= '0;
        out_data.phase_delay  <= '0;
        out_data.status       <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/slmli_ctrl.sv =====
// Controller: sequences one query through curve search, point search,
// division and interpolation. Depends on slmli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slmli_ctrl import slmli_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_stall
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_WL_LAST  = 16'h0002,
    S_WL_START = 16'h0004,
    S_WL_SCAN  = 16'h0008,
    S_CNT_RD   = 16'h0010,
    S_PT_START = 16'h0020,
    S_PT_SCAN  = 16'h0040,
    S_TAKE     = 16'h0080,
    S_DIV_INIT = 16'h0100,
    S_DIV      = 16'h0200,
    S_MUL_A    = 16'h0400,
    S_ADD_A    = 16'h0800,
    S_MUL_P    = 16'h1000,
    S_ADD_P    = 16'h2000,
    S_SAVE     = 16'h4000,
    S_EMIT     = 16'h8000
  } state_t;

  state_t state;
  state_t state_next;
  state_t curve_done;
  logic   err;
  logic   two;
  logic   on_upper;
  logic   wl_stage;

  assign in_stall = state != S_IDLE;

  // where to go once one curve (or the wavelength blend) is finished
  always_comb begin
    if (wl_stage) begin
      curve_done = S_EMIT;
    end else if (two && !on_upper) begin
      curve_done = S_SAVE;
    end else if (two) begin
      curve_done = S_DIV_INIT;
    end else begin
      curve_done = S_EMIT;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (stat.query_start) begin
          state_next = S_WL_LAST;
        end
      end
      S_WL_LAST: begin
        cmd.op     = OP_WL_LAST;
        state_next = S_WL_START;
      end
      S_WL_START: begin
        cmd.op     = OP_WL_START;
        state_next = S_WL_SCAN;
      end
      S_WL_SCAN: begin
        cmd.op = OP_WL_STEP;
        if (stat.wl_first && stat.wl_oob) begin
          state_next = S_EMIT;
        end else if (stat.wl_ge) begin
          state_next = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        cmd.op     = on_upper ? OP_CNT_UP : OP_CNT_LO;
        state_next = S_PT_START;
      end
      S_PT_START: begin
        cmd.op     = OP_PT_START;
        state_next = S_PT_SCAN;
      end
      S_PT_SCAN: begin
        cmd.op = OP_PT_STEP;
        if (stat.pt_ge || stat.pt_last) begin
          if (stat.pt_first || stat.pt_exact || !stat.pt_ge) begin
            state_next = S_TAKE;
          end else begin
            state_next = S_DIV_INIT;
          end
        end
      end
      S_TAKE: begin
        cmd.op     = OP_TAKE_PT;
        state_next = curve_done;
      end
      S_DIV_INIT: begin
        cmd.op     = wl_stage ? OP_DIV_WL : OP_DIV_CMD;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd.op     = wl_stage ? OP_MUL_AMP_W : OP_MUL_AMP_C;
        state_next = S_ADD_A;
      end
      S_ADD_A: begin
        cmd.op     = OP_ADD_AMP;
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.op     = wl_stage ? OP_MUL_PH_W : OP_MUL_PH_C;
        state_next = S_ADD_P;
      end
      S_ADD_P: begin
        cmd.op     = OP_ADD_PH;
        state_next = curve_done;
      end
      S_SAVE: begin
        cmd.op     = OP_SAVE_LO;
        state_next = S_CNT_RD;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = err ? OP_EMIT_ERR : OP_EMIT_OK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err      <= 1'b0;
      two      <= 1'b0;
      on_upper <= 1'b0;
      wl_stage <= 1'b0;
    end else begin
      state <= state_next;
      if (stat.query_start) begin
        err      <= 1'b0;
        two      <= 1'b0;
        on_upper <= 1'b0;
        wl_stage <= 1'b0;
      end
      if (state == S_WL_SCAN) begin
        if (stat.wl_first && stat.wl_oob) begin
          err <= 1'b1;
        end else if (stat.wl_ge) begin
          two      <= !(stat.wl_first || stat.wl_exact);
          on_upper <= stat.wl_first || stat.wl_exact;
        end
      end
      if (state == S_SAVE) begin
        on_upper <= 1'b1;
      end
      // both curves done: blend across wavelength next
      if ((state == S_TAKE || state == S_ADD_P) && !wl_stage && two && on_upper) begin
        wl_stage <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/slm_response_lut_interpolator.sv =====
// Top level of the two-dimensional response table interpolator.
// Depends on slmli_pkg, slmli_ctrl and slmli_dp.
//
//  port group     direction  handshake          payload
//  in_*           input      in_valid/in_stall   slm_in_t
//  out_*          output     out_valid/out_stall slm_out_t
//  cfg_*          input      cfg_wen             curves_in_use
//
// Loads are written to the table memories as they are accepted. A query
// walks the curve wavelengths one per cycle, then for each curve used walks
// its points one per cycle through the point memory read port; each
// interpolation adds a restoring divider, a set-up step and multiply/add
// steps, and the query ends only once the output is free. Reset clears
// control state and sets the curves-in-use setting to one; table memories
// are undefined until loaded.
// A result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module slm_response_lut_interpolator import slmli_pkg::*; #(
  parameter int MAX_CURVES = 16,
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  slm_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output slm_out_t         out_data,
  input  logic             cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_accept;

  assign in_accept = in_valid && !in_stall;

  slmli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  slmli_dp #(
    .MAX_CURVES (MAX_CURVES),
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .in_accept (in_accept),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a query transfer must lock out further input until it completes
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept && (in_data.mode == MODE_QUERY) |=> in_stall)
    else $error("input taken during a query");

  // loads never produce a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_accept && (in_data.mode != MODE_QUERY) |=> !$rose(out_valid))
    else $error("result appeared after a load");

  // out-of-domain results carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |->
      (out_data.transmission == '0) && (out_data.phase_delay == '0))
    else $error("error result with non-zero payload");

endmodule

`default_nettype wire
